// File: hdl/gf2fr_pkg.sv
// ----------------------------------------------------------------------------
// gf2fr_pkg
// Shared constants and types for the GF(2) Four Russians row reduction unit.
// ----------------------------------------------------------------------------
package gf2fr_pkg;

  // Fixed field widths of the stream and configuration beats.
  localparam int DATA_W = 64;
  localparam int COL_W  = 6;

  // Defaults for the top level parameters.
  localparam int ROW_BITS_DEF   = 64;
  localparam int TABLE_BITS_DEF = 4;

  // Item kind carried in the input tuser bit.
  localparam logic MODE_PIVOT  = 1'b0;
  localparam logic MODE_REDUCE = 1'b1;

  // Result strobe from the sequencer to the output register.
  typedef struct packed {
    logic valid;
    logic not_ready;
  } res_ctl_t;

  // Sequencer status seen by the top level.
  typedef struct packed {
    logic busy;
    logic table_ready;
  } seq_status_t;

endpackage

// File: hdl/gf2fr_ram.sv
// ----------------------------------------------------------------------------
// gf2fr_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module gf2fr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/gf2fr_seq.sv
// ----------------------------------------------------------------------------
// gf2fr_seq
// Table sequencer: builds the combination table from pivot rows by walking
// the built index list, and looks up table entries for reduce rows.
// ----------------------------------------------------------------------------
module gf2fr_seq #(
  parameter int ROW_BITS   = gf2fr_pkg::ROW_BITS_DEF,
  parameter int TABLE_BITS = gf2fr_pkg::TABLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [gf2fr_pkg::COL_W-1:0]   start_column,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [ROW_BITS-1:0]           in_row,
  input  logic                          out_free,
  output gf2fr_pkg::res_ctl_t           res,
  output logic [ROW_BITS-1:0]           res_row,
  output gf2fr_pkg::seq_status_t        status
);

  localparam int DEPTH = 1 << TABLE_BITS;
  localparam int CW    = $clog2(TABLE_BITS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LRD,
    S_TRD,
    S_WR,
    S_RED
  } state_t;

  state_t                state_r;
  logic [CW-1:0]         count_r;
  logic [TABLE_BITS-1:0] j_r;
  logic [TABLE_BITS-1:0] key_r;
  logic [TABLE_BITS-1:0] b_r;
  logic [ROW_BITS-1:0]   row_r;

  logic                  accept;
  logic                  table_ready;
  logic [CW-1:0]         count_eff;
  logic [TABLE_BITS-1:0] key_in;
  logic [TABLE_BITS:0]   half;
  logic                  last_step;

  logic                  tbl_we;
  logic [TABLE_BITS-1:0] tbl_waddr;
  logic [ROW_BITS-1:0]   tbl_wdata;
  logic [TABLE_BITS-1:0] tbl_raddr;
  logic [ROW_BITS-1:0]   tbl_rdata;

  logic                  lst_we;
  logic [TABLE_BITS-1:0] lst_waddr;
  logic [TABLE_BITS-1:0] lst_wdata;
  logic [TABLE_BITS-1:0] lst_raddr;
  logic [TABLE_BITS-1:0] lst_rdata;

  // Combination table and built index list.
  gf2fr_ram #(.WIDTH(ROW_BITS), .DEPTH(DEPTH)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  gf2fr_ram #(.WIDTH(TABLE_BITS), .DEPTH(DEPTH)) u_lst (
    .clk   (clk),
    .we    (lst_we),
    .waddr (lst_waddr),
    .wdata (lst_wdata),
    .raddr (lst_raddr),
    .rdata (lst_rdata)
  );

  // Handshake and key extraction.
  assign in_ready    = (state_r == S_IDLE) && out_free;
  assign accept      = in_valid && in_ready;
  assign table_ready = (count_r >= CW'(TABLE_BITS));
  assign count_eff   = table_ready ? '0 : count_r;
  assign key_in      = TABLE_BITS'(in_row >> start_column);

  // Pivot walk bookkeeping: half is the size of the set built so far.
  assign half      = (TABLE_BITS + 1)'(1) << count_r;
  assign last_step = ({1'b0, j_r} == (half - (TABLE_BITS + 1)'(1)));

  assign status.busy        = (state_r != S_IDLE);
  assign status.table_ready = table_ready;

  // Memory ports and result strobe.
  always_comb begin
    tbl_we        = 1'b0;
    tbl_waddr     = '0;
    tbl_wdata     = '0;
    tbl_raddr     = key_in;
    lst_we        = 1'b0;
    lst_waddr     = '0;
    lst_wdata     = '0;
    lst_raddr     = j_r;
    res.valid     = 1'b0;
    res.not_ready = 1'b0;
    res_row       = in_row;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_mode == gf2fr_pkg::MODE_PIVOT) begin
            // A new table starts from a cleared entry 0 and index 0.
            if (count_eff == '0) begin
              tbl_we = 1'b1;
              lst_we = 1'b1;
            end
          end else if (!table_ready) begin
            res.valid     = 1'b1;
            res.not_ready = 1'b1;
          end
        end
      end
      S_LRD: begin
        lst_raddr = j_r;
      end
      S_TRD: begin
        // Fetch the source entry and record the new index.
        tbl_raddr = lst_rdata;
        lst_we    = 1'b1;
        lst_waddr = j_r + half[TABLE_BITS-1:0];
        lst_wdata = lst_rdata ^ key_r;
      end
      S_WR: begin
        // Store the new combination and prefetch the next index.
        tbl_we    = 1'b1;
        tbl_waddr = b_r;
        tbl_wdata = tbl_rdata ^ row_r;
        lst_raddr = j_r + TABLE_BITS'(1);
      end
      S_RED: begin
        res.valid = 1'b1;
        res_row   = row_r ^ tbl_rdata;
      end
      default: begin
        tbl_we = 1'b0;
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      j_r     <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            row_r <= in_row;
            key_r <= key_in;
            j_r   <= '0;
            if (in_mode == gf2fr_pkg::MODE_PIVOT) begin
              count_r <= count_eff;
              state_r <= S_LRD;
            end else if (table_ready) begin
              state_r <= S_RED;
            end
          end
        end
        S_LRD: begin
          state_r <= S_TRD;
        end
        S_TRD: begin
          b_r     <= lst_rdata ^ key_r;
          state_r <= S_WR;
        end
        S_WR: begin
          if (last_step) begin
            count_r <= count_r + CW'(1);
            state_r <= S_IDLE;
          end else begin
            j_r     <= j_r + TABLE_BITS'(1);
            state_r <= S_TRD;
          end
        end
        S_RED: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/gf2_four_russians_row_reduce_unit.sv
// ----------------------------------------------------------------------------
// gf2_four_russians_row_reduce_unit
// GF(2) row elimination by the Four Russians method: pivot rows build a
// combination table, reduce rows are XORed with the entry their key selects.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Beat contents
// in_*      slave      tdata: row_data; tuser: mode (0 pivot, 1 reduce)
// out_*     master     tdata: reduced_row; tuser: not_ready
// cfg_*     slave      data: start_column (low column of the key field)
//
// A reduce row against a complete table does one table read with registered
// data; otherwise its not-ready result is strobed in the accept cycle. A pivot
// row takes the accept cycle, one list read, then a read and a write-back per
// built index. A reduce result waits in the output register; the next row is
// taken in the same cycle that register is emptied. Reset clears the pivot
// count and the start column; the table memories need no clearing pass.
// ----------------------------------------------------------------------------
module gf2_four_russians_row_reduce_unit #(
  parameter int ROW_BITS   = gf2fr_pkg::ROW_BITS_DEF,
  parameter int TABLE_BITS = gf2fr_pkg::TABLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input rows.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [gf2fr_pkg::DATA_W-1:0]      in_tdata,   // [63:0] row_data
  input  logic [0:0]                        in_tuser,   // [0] mode
  // Reduced rows.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gf2fr_pkg::DATA_W-1:0]      out_tdata,  // [63:0] reduced_row
  output logic [0:0]                        out_tuser,  // [0] not_ready
  // Configuration.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gf2fr_pkg::COL_W-1:0]       cfg_data    // [5:0] start_column
);

  localparam int DW = gf2fr_pkg::DATA_W;

  logic [gf2fr_pkg::COL_W-1:0] start_column_r;
  logic                        out_valid_r;
  logic [ROW_BITS-1:0]         out_row_r;
  logic                        out_nr_r;

  logic                        out_free;
  gf2fr_pkg::res_ctl_t         res;
  logic [ROW_BITS-1:0]         res_row;
  gf2fr_pkg::seq_status_t      status;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_column_r <= '0;
    end else if (cfg_valid) begin
      start_column_r <= cfg_data;
    end
  end

  // Table sequencer.
  gf2fr_seq #(.ROW_BITS(ROW_BITS), .TABLE_BITS(TABLE_BITS)) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_column (start_column_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_mode      (in_tuser[0]),
    .in_row       (in_tdata[ROW_BITS-1:0]),
    .out_free     (out_free),
    .res          (res),
    .res_row      (res_row),
    .status       (status)
  );

  // Output register.
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
      out_row_r   <= res_row;
      out_nr_r    <= res.not_ready;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = DW'(out_row_r);
  assign out_tuser[0] = out_nr_r;

  // A result never overwrites a beat that is still waiting.
  assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> out_free)
    else $error("result produced while output register is occupied");

  // The not-ready flag follows the table state.
  assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (res.not_ready == !status.table_ready))
    else $error("not_ready flag disagrees with table state");

  // A reduce row against a complete table yields its result in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser[0] == gf2fr_pkg::MODE_REDUCE)
      && status.table_ready) |=> (res.valid && !res.not_ready))
    else $error("reduce lookup did not complete on time");

endmodule
